// ----- src/lapet_pkg.sv -----
// ----------------------------------------------------------------------------
// lapet_pkg: shared types and constants of the Laplacian edge threshold block
// Field widths, command codes and the per-result side information that moves
// from the sequencer through the read stage to the output stage.
// ----------------------------------------------------------------------------
package lapet_pkg;

    // Field widths
    localparam int PIX_W = 8;
    localparam int CFG_W = 12;
    localparam int THR_W = 8;
    localparam int IDX_W = 2;

    // Input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd2;

    // Border handling and framing for one pending result
    typedef struct packed {
        logic row_first;   // top row: take the centre for the upper neighbour
        logic col_first;   // left column: take the centre for the left neighbour
        logic dn_sub;      // lower neighbour missing or past the bottom border
        logic rt_sub;      // right neighbour missing or past the right border
        logic frame_last;  // last pixel of the frame
    } lapet_meta_t;

endpackage

// ----- src/lapet_gray.sv -----
// ----------------------------------------------------------------------------
// lapet_gray: RGB to 8-bit gray conversion
// Fixed-point luma, (77R + 150G + 29B + 128) >> 8, rounded to nearest.
// ----------------------------------------------------------------------------
module lapet_gray
(
    input  logic [lapet_pkg::PIX_W-1:0] red,
    input  logic [lapet_pkg::PIX_W-1:0] green,
    input  logic [lapet_pkg::PIX_W-1:0] blue,
    output logic [lapet_pkg::PIX_W-1:0] gray
);
    import lapet_pkg::*;

    logic [15:0] luma_sum;

    // Weight the components, add the rounding half, keep the upper byte
    assign luma_sum = 16'd77  * {8'd0, red}
                    + 16'd150 * {8'd0, green}
                    + 16'd29  * {8'd0, blue}
                    + 16'd128;
    assign gray = luma_sum[15:8];

endmodule

// ----- src/lapet_ram.sv -----
// ----------------------------------------------------------------------------
// lapet_ram: gray pixel history memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module lapet_ram #(
    parameter int DEPTH  = 4100,
    parameter int ADDR_W = 13
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [lapet_pkg::PIX_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr_a,
    input  logic [ADDR_W-1:0]           rd_addr_b,
    output logic [lapet_pkg::PIX_W-1:0] rd_data_a,
    output logic [lapet_pkg::PIX_W-1:0] rd_data_b
);
    import lapet_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];

    // Store the newest gray pixel
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read both ports, hold the data while the next stage stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- src/lapet_seq.sv -----
// ----------------------------------------------------------------------------
// lapet_seq: stream sequencer
// Tracks the write pointer, the oldest pending pixel and its frame position,
// decides when a transaction produces a result and forms the history read
// addresses and border flags for that result.
// ----------------------------------------------------------------------------
module lapet_seq #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int RING_DEPTH = 4100,
    parameter int ADDR_W     = 13
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic                        command,
    input  logic [lapet_pkg::CFG_W-1:0] frame_width,
    input  logic [lapet_pkg::CFG_W-1:0] frame_height,
    output logic                        emit,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [ADDR_W-1:0]           addr_c,
    output logic [ADDR_W-1:0]           addr_rt,
    output logic [ADDR_W-1:0]           addr_up,
    output logic [ADDR_W-1:0]           addr_dn,
    output lapet_pkg::lapet_meta_t      meta_next
);
    import lapet_pkg::*;

    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PEND_W = $clog2(MAX_WIDTH + 3);
    localparam int SATW_W = (WID_W > CFG_W) ? WID_W : CFG_W;
    localparam int SATH_W = (HGT_W > CFG_W) ? HGT_W : CFG_W;
    localparam logic [ADDR_W:0]   RING_EXT = (ADDR_W + 1)'(RING_DEPTH);
    localparam logic [ADDR_W-1:0] RING_TOP = ADDR_W'(RING_DEPTH - 1);

    logic [ADDR_W-1:0] head_reg,    head_next;
    logic [ADDR_W-1:0] out_ptr_reg, out_ptr_next;
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    logic [SATW_W-1:0] fw_ext;
    logic [SATH_W-1:0] fh_ext;
    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic              is_drain;
    logic [PEND_W-1:0] pend_e;
    logic              row_last;
    logic              col_last;
    logic [ADDR_W:0]   ptr_ext;
    logic [ADDR_W:0]   w_ext;
    logic [ADDR_W:0]   dn_sum;
    logic [ADDR_W:0]   ptr_gap;

    // Saturate the geometry registers into the supported range
    assign fw_ext = SATW_W'(frame_width);
    assign fh_ext = SATH_W'(frame_height);
    assign w_eff  = (fw_ext == '0) ? WID_W'(1)
                  : (fw_ext > SATW_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : WID_W'(fw_ext);
    assign h_eff  = (fh_ext == '0) ? HGT_W'(1)
                  : (fh_ext > SATH_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : HGT_W'(fh_ext);

    // Decide whether this transaction releases the oldest pending pixel
    assign is_drain = (command == CMD_DRAIN);
    assign pend_e   = is_drain ? pending_reg : pending_reg + PEND_W'(1);
    assign emit     = is_drain ? (pending_reg != '0) : (pending_reg > PEND_W'(w_eff));

    // Border flags of the result position
    assign row_last = (HGT_W'(out_row_reg) >= h_eff - HGT_W'(1));
    assign col_last = (WID_W'(out_col_reg) >= w_eff - WID_W'(1));

    always_comb
    begin
        meta_next.row_first  = (out_row_reg == '0);
        meta_next.col_first  = (out_col_reg == '0);
        meta_next.dn_sub     = row_last || (pend_e <= PEND_W'(w_eff));
        meta_next.rt_sub     = col_last || (pend_e <= PEND_W'(1));
        meta_next.frame_last = row_last && col_last;
    end

    // Form the ring addresses around the centre pixel
    assign ptr_ext = {1'b0, out_ptr_reg};
    assign w_ext   = (ADDR_W + 1)'(w_eff);
    assign dn_sum  = ptr_ext + w_ext;
    assign addr_c  = out_ptr_reg;
    assign addr_rt = (out_ptr_reg == RING_TOP) ? '0 : out_ptr_reg + ADDR_W'(1);
    assign addr_dn = (dn_sum >= RING_EXT) ? ADDR_W'(dn_sum - RING_EXT) : ADDR_W'(dn_sum);
    assign addr_up = (ptr_ext >= w_ext) ? ADDR_W'(ptr_ext - w_ext)
                                        : ADDR_W'(ptr_ext + RING_EXT - w_ext);

    // Write pixels at the head of the ring
    assign wr_en   = fire && !is_drain;
    assign wr_addr = head_reg;

    // Advance pointers, pending count and result position
    always_comb
    begin
        head_next    = head_reg;
        out_ptr_next = out_ptr_reg;
        pending_next = pending_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (fire)
        begin
            if (!is_drain)
            begin
                head_next = (head_reg == RING_TOP) ? '0 : head_reg + ADDR_W'(1);
            end
            pending_next = pend_e;
            if (emit)
            begin
                pending_next = pend_e - PEND_W'(1);
                out_ptr_next = addr_rt;
                if (col_last)
                begin
                    out_col_next = '0;
                    out_row_next = row_last ? '0 : out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            out_ptr_reg <= '0;
            pending_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            head_reg    <= head_next;
            out_ptr_reg <= out_ptr_next;
            pending_reg <= pending_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Distance from the oldest pending pixel to the head of the ring
    assign ptr_gap = (head_reg >= out_ptr_reg)
                   ? {1'b0, head_reg} - ptr_ext
                   : {1'b0, head_reg} + RING_EXT - ptr_ext;

    // The pending count never exceeds one row plus one pixel
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(MAX_WIDTH + 1))
        else $error("pending count above one row plus one pixel");

    // The pointers stay exactly the pending count apart
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_gap == (ADDR_W + 1)'(pending_reg))
        else $error("ring pointers disagree with pending count");

    // A drain with nothing pending leaves the result position alone
    a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_drain && pending_reg == '0)
        |=> ($stable(out_ptr_reg) && $stable(out_col_reg) && $stable(out_row_reg)))
        else $error("empty drain moved the result position");

endmodule

// ----- src/lapet_calc.sv -----
// ----------------------------------------------------------------------------
// lapet_calc: Laplacian and threshold stage
// Holds the border flags beside the history read data, forms
// 4*centre - up - down - left - right with edge replication and registers
// the thresholded result for the output channel.
// ----------------------------------------------------------------------------
module lapet_calc
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s2_in_valid,
    input  lapet_pkg::lapet_meta_t      meta_next,
    input  logic [lapet_pkg::PIX_W-1:0] c_data,
    input  logic [lapet_pkg::PIX_W-1:0] rt_data,
    input  logic [lapet_pkg::PIX_W-1:0] up_data,
    input  logic [lapet_pkg::PIX_W-1:0] dn_data,
    input  logic [lapet_pkg::THR_W-1:0] threshold,
    input  logic                        out_ready,
    output logic                        s2_ready,
    output logic                        out_valid,
    output logic                        edge_res,
    output logic                        frame_last
);
    import lapet_pkg::*;

    logic              s2_valid_reg;
    lapet_meta_t       meta_reg;
    logic [PIX_W-1:0]  prev_c_reg;
    logic              out_valid_reg;
    logic              edge_res_reg;
    logic              frame_last_reg;

    logic              s3_ready;
    logic              s2_fire;
    logic [PIX_W-1:0]  up_v;
    logic [PIX_W-1:0]  dn_v;
    logic [PIX_W-1:0]  lf_v;
    logic [PIX_W-1:0]  rt_v;
    logic [9:0]        nb_sum;
    logic [10:0]       limit;
    logic [10:0]       centre4;
    logic              edge_next;

    // Stage handshake
    assign s3_ready = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s2_fire  = s2_valid_reg && s3_ready;

    // Replicate the centre across borders and missing neighbours
    assign up_v = meta_reg.row_first ? c_data : up_data;
    assign dn_v = meta_reg.dn_sub    ? c_data : dn_data;
    assign lf_v = meta_reg.col_first ? c_data : prev_c_reg;
    assign rt_v = meta_reg.rt_sub    ? c_data : rt_data;

    // Compare 4*centre against neighbour sum plus threshold
    assign nb_sum    = {2'b0, up_v} + {2'b0, dn_v} + {2'b0, lf_v} + {2'b0, rt_v};
    assign limit     = {1'b0, nb_sum} + {3'b0, threshold};
    assign centre4   = {1'b0, c_data, 2'b00};
    assign edge_next = (centre4 > limit);

    // Track stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= s2_in_valid;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Load flags, keep the centre as the next left neighbour, register result
    always_ff @(posedge clk)
    begin
        if (s2_in_valid && s2_ready)
        begin
            meta_reg <= meta_next;
        end
        if (s2_fire)
        begin
            prev_c_reg     <= c_data;
            edge_res_reg   <= edge_next;
            frame_last_reg <= meta_reg.frame_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_res   = edge_res_reg;
    assign frame_last = frame_last_reg;

    // A stalled read stage keeps its result and flags
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_ready) |=> (s2_valid_reg && $stable(meta_reg)))
        else $error("read stage lost a stalled result");

endmodule

// ----- src/laplacian_edge_threshold.sv -----
// ----------------------------------------------------------------------------
// laplacian_edge_threshold: 3x3 Laplacian edge detector on an RGB stream
// Converts raster-order RGB pixels to gray, keeps a pixel history ring and
// marks each pixel whose 4-neighbour Laplacian exceeds a threshold.
// ----------------------------------------------------------------------------
// Usage: send pixels (command 0) with red, green, blue on the input channel
// in raster order, frames back to back. A result for a pixel comes out once
// one row plus one more pixel has arrived after it; at the end of the stream
// send drain transactions (command 1), one per pending result. frame_last
// marks the result of the last pixel of each frame.
// Configuration: write frame_width (index 0), frame_height (index 1) and
// edge_threshold (index 2) through the cfg channel while the stream is idle;
// cfg_ready is always high.
// Timing: one transaction per clock, sustained while out_ready stays high. A
// result is presented in the output register once the transaction that
// releases it has passed the input register and the history read stage.
// Reset clears positions and pending count; the history memory needs no
// clearing pass. When the receiver stalls, results back up through the
// output register and read stage, then in_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module laplacian_edge_threshold #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [lapet_pkg::PIX_W-1:0] red,
    input  logic [lapet_pkg::PIX_W-1:0] green,
    input  logic [lapet_pkg::PIX_W-1:0] blue,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        edge_res,
    output logic                        frame_last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lapet_pkg::IDX_W-1:0] cfg_index,
    input  logic [lapet_pkg::CFG_W-1:0] cfg_data
);
    import lapet_pkg::*;

    localparam int RING_DEPTH = 2 * MAX_WIDTH + 4;
    localparam int ADDR_W     = $clog2(RING_DEPTH);

    logic [CFG_W-1:0]  frame_width_reg;
    logic [CFG_W-1:0]  frame_height_reg;
    logic [THR_W-1:0]  threshold_reg;

    logic              in_valid_reg;
    logic              command_reg;
    logic [PIX_W-1:0]  red_reg;
    logic [PIX_W-1:0]  green_reg;
    logic [PIX_W-1:0]  blue_reg;

    logic              s2_ready;
    logic              fire;
    logic              emit;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] addr_c;
    logic [ADDR_W-1:0] addr_rt;
    logic [ADDR_W-1:0] addr_up;
    logic [ADDR_W-1:0] addr_dn;
    lapet_meta_t       meta_next;
    logic              s2_in_valid;
    logic [PIX_W-1:0]  gray;
    logic [PIX_W-1:0]  c_data;
    logic [PIX_W-1:0]  rt_data;
    logic [PIX_W-1:0]  up_data;
    logic [PIX_W-1:0]  dn_data;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W'(2048);
            frame_height_reg <= CFG_W'(2048);
            threshold_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_THRESHOLD:    threshold_reg    <= cfg_data[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register: take a transaction when empty or moving on
    assign fire     = in_valid_reg && s2_ready;
    assign in_ready = !in_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            command_reg <= command;
            red_reg     <= red;
            green_reg   <= green;
            blue_reg    <= blue;
        end
    end

    lapet_gray u_gray
    (
        .red   (red_reg),
        .green (green_reg),
        .blue  (blue_reg),
        .gray  (gray)
    );

    lapet_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RING_DEPTH (RING_DEPTH),
        .ADDR_W     (ADDR_W)
    )
    u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .command      (command_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .emit         (emit),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .addr_c       (addr_c),
        .addr_rt      (addr_rt),
        .addr_up      (addr_up),
        .addr_dn      (addr_dn),
        .meta_next    (meta_next)
    );

    // Read the history for a released result
    assign s2_in_valid = fire && emit;

    lapet_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (ADDR_W)
    )
    u_ram_a
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (gray),
        .rd_en     (s2_in_valid),
        .rd_addr_a (addr_c),
        .rd_addr_b (addr_rt),
        .rd_data_a (c_data),
        .rd_data_b (rt_data)
    );

    lapet_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (ADDR_W)
    )
    u_ram_b
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (gray),
        .rd_en     (s2_in_valid),
        .rd_addr_a (addr_up),
        .rd_addr_b (addr_dn),
        .rd_data_a (up_data),
        .rd_data_b (dn_data)
    );

    lapet_calc u_calc
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s2_in_valid (s2_in_valid),
        .meta_next   (meta_next),
        .c_data      (c_data),
        .rt_data     (rt_data),
        .up_data     (up_data),
        .dn_data     (dn_data),
        .threshold   (threshold_reg),
        .out_ready   (out_ready),
        .s2_ready    (s2_ready),
        .out_valid   (out_valid),
        .edge_res    (edge_res),
        .frame_last  (frame_last)
    );

endmodule
